// File: sv/are_pkg.sv
`timescale 1ns / 1ps
package are_pkg;

   localparam logic [1:0]  OPCODE_SEND   = 2'd0;
   localparam logic [1:0]  OPCODE_FRAME  = 2'd1;
   localparam logic [1:0]  OPCODE_TICK   = 2'd2;
   localparam logic [1:0]  OPCODE_UNUSED = 2'd3;

   localparam logic [2:0]  KIND_ARP_REQUEST = 3'd0;
   localparam logic [2:0]  KIND_ARP_REPLY   = 3'd1;
   localparam logic [2:0]  KIND_IPV4_FRAME  = 3'd2;
   localparam logic [2:0]  KIND_DELIVER     = 3'd3;
   localparam logic [2:0]  KIND_DROPPED     = 3'd4;

   localparam logic [47:0] MAC_BCAST  = 48'hFFFF_FFFF_FFFF;
   localparam logic [15:0] ETH_IP4    = 16'h0800;
   localparam logic [15:0] ETH_ARP    = 16'h0806;
   localparam logic [15:0] ARP_OP_REQ = 16'd1;
   localparam logic [15:0] ARP_OP_REP = 16'd2;

   localparam logic [1:0]  CSR_OWN_MAC      = 2'd0;
   localparam logic [1:0]  CSR_OWN_IP       = 2'd1;
   localparam logic [1:0]  CSR_CACHE_TTL_MS = 2'd2;
   localparam logic [1:0]  CSR_RETRY_MS     = 2'd3;

   localparam logic [31:0] CACHE_TTL_RESET = 32'd30000;
   localparam logic [31:0] RETRY_RESET     = 32'd5000;

   // queued command codes
   localparam logic [1:0]  CMD_SEND    = 2'd0;
   localparam logic [1:0]  CMD_DELIVER = 2'd1;
   localparam logic [1:0]  CMD_ARP     = 2'd2;
   localparam logic [1:0]  CMD_TICK    = 2'd3;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] hop_ip;
      logic [15:0] dgram_handle;
      logic [47:0] frame_dst_mac;
      logic [15:0] ether_type;
      logic        parse_ok;
      logic [15:0] arp_op;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip_in;
      logic [47:0] target_mac_in;
      logic [31:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [47:0] dest_mac;
      logic [31:0] arp_target_ip;
      logic [15:0] handle_out;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] own_mac;
      logic [31:0] own_ip;
      logic [31:0] cache_ttl_ms;
      logic [31:0] retry_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  code;
      logic        is_req;
      logic [31:0] ip;
      logic [47:0] mac;
      logic [15:0] handle;
      logic [31:0] elapsed;
   } cmd_type;

endpackage

// File: sv/arp_resolution_engine.sv
`timescale 1ns / 1ps
// ARP learn visits each parked entry, after a scan for a victim when the cache
// is full; tick ages the cache, then walks each entry of the wait table.
// The back end takes one transaction at a time, walking the wait table and the
// parked store (one memory read port) entry by entry.
// A two-entry queue takes new transactions while the back end works.
// Reset is synchronous: valid bits, counters and config go to reset values at once.
module arp_resolution_engine #(
   parameter int CACHE_ENTRIES  = 16,
   parameter int WAIT_ENTRIES   = 8,
   parameter int PARKED_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  are_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output are_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [47:0]      csr_wdata
);

   are_pkg::cfg_type cfg_ff;
   logic             q_valid;
   logic             q_pop;
   are_pkg::cmd_type q_cmd;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac      <= '0;
         cfg_ff.own_ip       <= '0;
         cfg_ff.cache_ttl_ms <= are_pkg::CACHE_TTL_RESET;
         cfg_ff.retry_ms     <= are_pkg::RETRY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            are_pkg::CSR_OWN_MAC:      cfg_ff.own_mac      <= csr_wdata;
            are_pkg::CSR_OWN_IP:       cfg_ff.own_ip       <= csr_wdata[31:0];
            are_pkg::CSR_CACHE_TTL_MS: cfg_ff.cache_ttl_ms <= csr_wdata[31:0];
            default:                   cfg_ff.retry_ms     <= csr_wdata[31:0];
         endcase
      end
   end

   // front: filter and classify, queue commands
   are_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop)
   );

   // back: tables, parked store, result sequencing
   are_back #(
      .CACHE_ENTRIES  (CACHE_ENTRIES),
      .WAIT_ENTRIES   (WAIT_ENTRIES),
      .PARKED_ENTRIES (PARKED_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sv/are_front.sv
`timescale 1ns / 1ps
module are_front (
   input  logic             clock,
   input  logic             reset,
   input  are_pkg::cfg_type cfg,
   input  logic             req_valid,
   output logic             req_stall,
   input  are_pkg::req_type req_data,
   output logic             q_valid,
   output are_pkg::cmd_type q_cmd,
   input  logic             q_pop
);

   are_pkg::cmd_type cmd;
   logic             keep;
   logic             is_req;
   logic             is_rep;

   are_pkg::cmd_type fifo_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             push;

   // classify; items with no effect never enter the queue
   always_comb begin
      keep        = 1'b0;
      is_req      = (req_data.arp_op == are_pkg::ARP_OP_REQ) &&
                    (req_data.target_ip_in == cfg.own_ip);
      is_rep      = (req_data.arp_op == are_pkg::ARP_OP_REP) &&
                    (req_data.target_mac_in == cfg.own_mac);
      cmd.code    = are_pkg::CMD_SEND;
      cmd.is_req  = is_req;
      cmd.ip      = req_data.sender_ip;
      cmd.mac     = req_data.sender_mac;
      cmd.handle  = req_data.dgram_handle;
      cmd.elapsed = req_data.elapsed_ms;
      unique case (req_data.opcode)
         are_pkg::OPCODE_SEND: begin
            keep   = 1'b1;
            cmd.ip = req_data.hop_ip;
         end
         are_pkg::OPCODE_FRAME: begin
            if (((req_data.frame_dst_mac == cfg.own_mac) ||
                 (req_data.frame_dst_mac == are_pkg::MAC_BCAST)) &&
                req_data.parse_ok) begin
               if (req_data.ether_type == are_pkg::ETH_IP4) begin
                  keep     = 1'b1;
                  cmd.code = are_pkg::CMD_DELIVER;
               end else if (req_data.ether_type == are_pkg::ETH_ARP) begin
                  keep     = is_req || is_rep;
                  cmd.code = are_pkg::CMD_ARP;
               end
            end
         end
         are_pkg::OPCODE_TICK: begin
            keep     = 1'b1;
            cmd.code = are_pkg::CMD_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (q_pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, q_pop};
      end
   end

endmodule

// File: sv/are_back.sv
`timescale 1ns / 1ps
module are_back #(
   parameter int CACHE_ENTRIES  = 16,
   parameter int WAIT_ENTRIES   = 8,
   parameter int PARKED_ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  are_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  are_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output are_pkg::rsp_type rsp_data
);

   localparam int CAW  = $clog2(CACHE_ENTRIES);
   localparam int WAW  = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
   localparam int PAW  = (PARKED_ENTRIES > 1) ? $clog2(PARKED_ENTRIES) : 1;
   localparam int PCW  = $clog2(PARKED_ENTRIES + 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SEND  = 4'd1;
   localparam logic [3:0] ST_DELIV = 4'd2;
   localparam logic [3:0] ST_RX    = 4'd3;
   localparam logic [3:0] ST_MIN   = 4'd4;
   localparam logic [3:0] ST_FL_RD = 4'd5;
   localparam logic [3:0] ST_FL_EX = 4'd6;
   localparam logic [3:0] ST_TICK  = 4'd7;
   localparam logic [3:0] ST_WAIT  = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [3:0] state_ff, state_in;
   are_pkg::cmd_type cmd_ff, cmd_in;

   logic        cache_valid_ff [CACHE_ENTRIES];
   logic        cache_valid_in [CACHE_ENTRIES];
   logic [31:0] cache_ip_ff    [CACHE_ENTRIES];
   logic [31:0] cache_ip_in    [CACHE_ENTRIES];
   logic [47:0] cache_mac_ff   [CACHE_ENTRIES];
   logic [47:0] cache_mac_in   [CACHE_ENTRIES];
   logic [31:0] cache_ttl_ff   [CACHE_ENTRIES];
   logic [31:0] cache_ttl_in   [CACHE_ENTRIES];

   logic        wait_valid_ff [WAIT_ENTRIES];
   logic        wait_valid_in [WAIT_ENTRIES];
   logic [31:0] wait_ip_ff    [WAIT_ENTRIES];
   logic [31:0] wait_ip_in    [WAIT_ENTRIES];
   logic [31:0] wait_timer_ff [WAIT_ENTRIES];
   logic [31:0] wait_timer_in [WAIT_ENTRIES];

   logic [PCW-1:0] parked_count_ff, parked_count_in;
   logic [31:0]    parked_ip_mem     [PARKED_ENTRIES];
   logic [15:0]    parked_handle_mem [PARKED_ENTRIES];
   logic [31:0]    parked_rd_ip_ff;
   logic [15:0]    parked_rd_handle_ff;
   logic           park_we;
   logic [PAW-1:0] park_waddr;
   logic [31:0]    park_wip;
   logic [15:0]    park_whandle;

   logic [PCW-1:0] fl_idx_ff, fl_idx_in;
   logic [PCW-1:0] keep_ff, keep_in;
   logic [CAW-1:0] min_idx_ff, min_idx_in;
   logic [CAW-1:0] best_idx_ff, best_idx_in;
   logic [31:0]    best_ttl_ff, best_ttl_in;
   logic [WAW-1:0] wj_ff, wj_in;

   are_pkg::rsp_type pend_ff, pend_in;
   logic             pend_valid_ff, pend_valid_in;
   are_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             out_free, can_emit, emit;
   are_pkg::rsp_type emit_data;

   logic           c_hit, c_free, w_hit, w_free;
   logic [CAW-1:0] c_hit_idx, c_free_idx, nb_idx;
   logic [WAW-1:0] w_hit_idx, w_free_idx;
   logic [31:0]    look_ip;
   logic [CAW-1:0] slot;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !pend_valid_ff || out_free;
   assign look_ip  = cmd_ff.ip;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid;

   // parallel lookups, lowest index wins
   always_comb begin
      c_hit = 1'b0; c_hit_idx = '0; c_free = 1'b0; c_free_idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (cache_valid_ff[i] && cache_ip_ff[i] == look_ip) begin
            c_hit = 1'b1; c_hit_idx = CAW'(i);
         end
         if (!cache_valid_ff[i]) begin
            c_free = 1'b1; c_free_idx = CAW'(i);
         end
      end
      w_hit = 1'b0; w_hit_idx = '0; w_free = 1'b0; w_free_idx = '0;
      for (int i = WAIT_ENTRIES - 1; i >= 0; i--) begin
         if (wait_valid_ff[i] && wait_ip_ff[i] == look_ip) begin
            w_hit = 1'b1; w_hit_idx = WAW'(i);
         end
         if (!wait_valid_ff[i]) begin
            w_free = 1'b1; w_free_idx = WAW'(i);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      cache_valid_in  = cache_valid_ff;
      cache_ip_in     = cache_ip_ff;
      cache_mac_in    = cache_mac_ff;
      cache_ttl_in    = cache_ttl_ff;
      wait_valid_in   = wait_valid_ff;
      wait_ip_in      = wait_ip_ff;
      wait_timer_in   = wait_timer_ff;
      parked_count_in = parked_count_ff;
      fl_idx_in       = fl_idx_ff;
      keep_in         = keep_ff;
      min_idx_in      = min_idx_ff;
      best_idx_in     = best_idx_ff;
      best_ttl_in     = best_ttl_ff;
      wj_in           = wj_ff;
      park_we         = 1'b0;
      park_waddr      = parked_count_ff[PAW-1:0];
      park_wip        = cmd_ff.ip;
      park_whandle    = cmd_ff.handle;
      emit            = 1'b0;
      emit_data       = '0;
      slot            = c_hit ? c_hit_idx : c_free_idx;
      nb_idx          = best_idx_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               unique case (q_cmd.code)
                  are_pkg::CMD_SEND:    state_in = ST_SEND;
                  are_pkg::CMD_DELIVER: state_in = ST_DELIV;
                  are_pkg::CMD_ARP:     state_in = ST_RX;
                  default:              state_in = ST_TICK;
               endcase
            end
         end
         ST_SEND: begin
            if (can_emit) begin
               state_in = ST_DONE;
               if (c_hit) begin
                  emit                 = 1'b1;
                  emit_data.kind       = are_pkg::KIND_IPV4_FRAME;
                  emit_data.dest_mac   = cache_mac_ff[c_hit_idx];
                  emit_data.handle_out = cmd_ff.handle;
               end else if ((parked_count_ff >= PCW'(PARKED_ENTRIES)) ||
                            (!w_hit && !w_free)) begin
                  emit                 = 1'b1;
                  emit_data.kind       = are_pkg::KIND_DROPPED;
                  emit_data.handle_out = cmd_ff.handle;
               end else begin
                  if (!w_hit) begin
                     wait_valid_in[w_free_idx] = 1'b1;
                     wait_ip_in[w_free_idx]    = cmd_ff.ip;
                     wait_timer_in[w_free_idx] = cfg.retry_ms;
                     emit                    = 1'b1;
                     emit_data.kind          = are_pkg::KIND_ARP_REQUEST;
                     emit_data.dest_mac      = are_pkg::MAC_BCAST;
                     emit_data.arp_target_ip = cmd_ff.ip;
                  end
                  park_we         = 1'b1;
                  parked_count_in = parked_count_ff + 1'b1;
               end
            end
         end
         ST_DELIV: begin
            if (can_emit) begin
               emit                 = 1'b1;
               emit_data.kind       = are_pkg::KIND_DELIVER;
               emit_data.handle_out = cmd_ff.handle;
               state_in             = ST_DONE;
            end
         end
         ST_RX: begin
            if (!cmd_ff.is_req || can_emit) begin
               if (cmd_ff.is_req) begin
                  emit                    = 1'b1;
                  emit_data.kind          = are_pkg::KIND_ARP_REPLY;
                  emit_data.dest_mac      = cmd_ff.mac;
                  emit_data.arp_target_ip = cmd_ff.ip;
               end
               if (w_hit) wait_valid_in[w_hit_idx] = 1'b0;
               fl_idx_in = '0;
               keep_in   = '0;
               if (c_hit || c_free) begin
                  cache_valid_in[slot] = 1'b1;
                  cache_ip_in[slot]    = cmd_ff.ip;
                  cache_mac_in[slot]   = cmd_ff.mac;
                  cache_ttl_in[slot]   = cfg.cache_ttl_ms;
                  state_in             = ST_FL_RD;
               end else begin
                  min_idx_in  = CAW'(1);
                  best_idx_in = '0;
                  best_ttl_in = cache_ttl_ff[0];
                  state_in    = ST_MIN;
               end
            end
         end
         ST_MIN: begin
            // replacement victim: least remaining ttl, lowest index on a tie
            if (cache_ttl_ff[min_idx_ff] < best_ttl_ff) begin
               nb_idx      = min_idx_ff;
               best_ttl_in = cache_ttl_ff[min_idx_ff];
            end
            best_idx_in = nb_idx;
            min_idx_in  = min_idx_ff + 1'b1;
            if (min_idx_ff == CAW'(CACHE_ENTRIES - 1)) begin
               cache_valid_in[nb_idx] = 1'b1;
               cache_ip_in[nb_idx]    = cmd_ff.ip;
               cache_mac_in[nb_idx]   = cmd_ff.mac;
               cache_ttl_in[nb_idx]   = cfg.cache_ttl_ms;
               state_in               = ST_FL_RD;
            end
         end
         ST_FL_RD: begin
            if (fl_idx_ff >= parked_count_ff) begin
               parked_count_in = keep_ff;
               state_in        = ST_DONE;
            end else begin
               state_in = ST_FL_EX;
            end
         end
         ST_FL_EX: begin
            if (parked_rd_ip_ff == cmd_ff.ip) begin
               if (can_emit) begin
                  emit                 = 1'b1;
                  emit_data.kind       = are_pkg::KIND_IPV4_FRAME;
                  emit_data.dest_mac   = cmd_ff.mac;
                  emit_data.handle_out = parked_rd_handle_ff;
                  fl_idx_in            = fl_idx_ff + 1'b1;
                  state_in             = ST_FL_RD;
               end
            end else begin
               // compact survivors toward the front, order kept
               park_we      = 1'b1;
               park_waddr   = keep_ff[PAW-1:0];
               park_wip     = parked_rd_ip_ff;
               park_whandle = parked_rd_handle_ff;
               keep_in      = keep_ff + 1'b1;
               fl_idx_in    = fl_idx_ff + 1'b1;
               state_in     = ST_FL_RD;
            end
         end
         ST_TICK: begin
            for (int i = 0; i < CACHE_ENTRIES; i++) begin
               if (cache_valid_ff[i]) begin
                  if (cache_ttl_ff[i] <= cmd_ff.elapsed) cache_valid_in[i] = 1'b0;
                  else cache_ttl_in[i] = cache_ttl_ff[i] - cmd_ff.elapsed;
               end
            end
            wj_in    = '0;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (wait_valid_ff[wj_ff] && wait_timer_ff[wj_ff] <= cmd_ff.elapsed) begin
               if (can_emit) begin
                  emit                    = 1'b1;
                  emit_data.kind          = are_pkg::KIND_ARP_REQUEST;
                  emit_data.dest_mac      = are_pkg::MAC_BCAST;
                  emit_data.arp_target_ip = wait_ip_ff[wj_ff];
                  wait_timer_in[wj_ff]    = cfg.retry_ms;
                  wj_in                   = wj_ff + 1'b1;
                  if (wj_ff == WAW'(WAIT_ENTRIES - 1)) state_in = ST_DONE;
               end
            end else begin
               if (wait_valid_ff[wj_ff]) begin
                  wait_timer_in[wj_ff] = wait_timer_ff[wj_ff] - cmd_ff.elapsed;
               end
               wj_in = wj_ff + 1'b1;
               if (wj_ff == WAW'(WAIT_ENTRIES - 1)) state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // one-deep hold: a result leaves only once it is known whether it is the last
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_ff;
         end
         pend_in       = emit_data;
         pend_valid_in = 1'b1;
      end else if (state_ff == ST_DONE && pend_valid_ff && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_data_in      = pend_ff;
         rsp_data_in.last = 1'b1;
         pend_valid_in    = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (park_we) begin
         parked_ip_mem[park_waddr]     <= park_wip;
         parked_handle_mem[park_waddr] <= park_whandle;
      end
      if (state_ff == ST_FL_RD) begin
         parked_rd_ip_ff     <= parked_ip_mem[fl_idx_ff[PAW-1:0]];
         parked_rd_handle_ff <= parked_handle_mem[fl_idx_ff[PAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      cache_ip_ff   <= cache_ip_in;
      cache_mac_ff  <= cache_mac_in;
      cache_ttl_ff  <= cache_ttl_in;
      wait_ip_ff    <= wait_ip_in;
      wait_timer_ff <= wait_timer_in;
      fl_idx_ff     <= fl_idx_in;
      keep_ff       <= keep_in;
      min_idx_ff    <= min_idx_in;
      best_idx_ff   <= best_idx_in;
      best_ttl_ff   <= best_ttl_in;
      wj_ff         <= wj_in;
      pend_ff       <= pend_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         parked_count_ff <= '0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < CACHE_ENTRIES; i++) cache_valid_ff[i] <= 1'b0;
         for (int i = 0; i < WAIT_ENTRIES; i++) wait_valid_ff[i] <= 1'b0;
      end else begin
         state_ff        <= state_in;
         parked_count_ff <= parked_count_in;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         cache_valid_ff  <= cache_valid_in;
         wait_valid_ff   <= wait_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_park_bound: assert property (@(posedge clock) disable iff (reset)
      parked_count_ff <= PCW'(PARKED_ENTRIES))
      else $error("parked count past capacity");
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left behind at idle");
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && pend_valid_ff && out_free) |=>
         (rsp_valid_ff && rsp_data_ff.last))
      else $error("closing transaction not marked last");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff != ST_IDLE))
      else $error("popped command not started");
`endif

endmodule
